// File: sv/cdas_pkg.sv
// cdas_pkg: shared types, constants and calendar helper functions
// for the date add/subtract/diff unit. No dependencies.
package cdas_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_ADD  = 2'd1,
    FUNC_SUB  = 2'd2,
    FUNC_DIFF = 2'd3
  } func_t;

  localparam logic [11:0] YEAR_MIN  = 12'd1900;
  localparam logic [11:0] YEAR_MAX  = 12'd2900;
  localparam logic [3:0]  MONTH_DEF = 4'd1;
  localparam logic [4:0]  DAY_DEF   = 5'd1;
  localparam int          DN_W      = 21;
  localparam int          CNT_W     = 19;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  localparam date_t DATE_DEF = '{year: YEAR_MIN, month: MONTH_DEF, day: DAY_DEF};

  // v / 100 for v < 4096, by reciprocal 5243 / 2^19
  function automatic logic [5:0] div100(input logic [11:0] v);
    logic [24:0] pr;
    pr = 25'(v) * 25'd5243;
    return pr[24:19];
  endfunction

  function automatic logic is_leap(input logic [11:0] y);
    logic [11:0] r100;
    logic [9:0]  q;
    logic [9:0]  r400;
    r100 = y - 12'(div100(y) * 7'd100);
    q    = y[11:2];
    r400 = q - 10'(div100({2'b00, q}) * 7'd100);
    return (y[1:0] == 2'b00) && ((r100 != 12'd0) || (r400 == 10'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [11:0] y);
    logic [4:0] len;
    case (m)
      4'd2:                      len = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic date_ok(input date_t dt);
    return (dt.year >= YEAR_MIN) && (dt.year <= YEAR_MAX) &&
           (dt.month >= 4'd1) && (dt.month <= 4'd12) &&
           (dt.day >= 5'd1) && (dt.day <= month_len(dt.month, dt.year));
  endfunction

  // days before month m in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

// File: sv/calendar_date_add_sub_diff_unit.sv
// calendar_date_add_sub_diff_unit: top level, holds the stored date and
// sequences load, add, subtract and diff. Uses cdas_pkg, cdas_step, cdas_daynum.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | func, arg_year, arg_month, arg_day, day_count
//  out     | out_valid/out_stall| out_year, out_month, out_day, distance, error_flag
//
// Diff uses the day-number unit once per date.
// Add/sub: the stepper runs until the count is used up; a step covers the rest
// of a month or one month turn, so about 2 steps per 31 days.
// rst returns the date to 1900-01-01 and empties the output register.
// A new item is taken while a result waits; the result stage waits on out_stall.
module calendar_date_add_sub_diff_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [11:0] arg_year,
  input  logic [3:0]  arg_month,
  input  logic [4:0]  arg_day,
  input  logic [18:0] day_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [18:0] distance,
  output logic        error_flag
);

  typedef enum logic [2:0] {
    S_IDLE, S_STEP, S_DNA, S_DNB, S_DNC, S_FIN
  } state_t;

  state_t                       state;
  cdas_pkg::date_t              cur;
  cdas_pkg::date_t              opnd;
  cdas_pkg::date_t              arg;
  cdas_pkg::date_t              step_nxt;
  cdas_pkg::date_t              dn_in;
  logic [cdas_pkg::CNT_W-1:0]   n;
  logic [cdas_pkg::CNT_W-1:0]   n_next;
  logic [cdas_pkg::CNT_W-1:0]   span;
  logic [cdas_pkg::DN_W-1:0]    dn;
  logic [cdas_pkg::DN_W-1:0]    dn_a;
  logic                         back;
  logic                         err;
  logic                         step_err;
  logic                         in_acc;

  assign arg      = '{year: arg_year, month: arg_month, day: arg_day};
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign dn_in    = (state == S_DNA) ? cur : opnd;

  cdas_step u_step (
    .cur   (cur),
    .n     (n),
    .back  (back),
    .nxt   (step_nxt),
    .n_nxt (n_next),
    .err   (step_err)
  );

  cdas_daynum u_dn (
    .clk (clk),
    .dt  (dn_in),
    .dn  (dn)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= cdas_pkg::DATE_DEF;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            err  <= 1'b0;
            span <= '0;
            n    <= day_count;
            back <= (func == cdas_pkg::FUNC_SUB);
            opnd <= arg;
            case (func)
              cdas_pkg::FUNC_LOAD: begin
                if (cdas_pkg::date_ok(arg)) begin
                  cur <= arg;
                end else begin
                  cur <= cdas_pkg::DATE_DEF;
                  err <= 1'b1;
                end
                state <= S_FIN;
              end
              cdas_pkg::FUNC_DIFF: begin
                if (!cdas_pkg::date_ok(arg)) begin
                  opnd <= cdas_pkg::DATE_DEF;
                  err  <= 1'b1;
                end
                state <= S_DNA;
              end
              default: state <= S_STEP;
            endcase
          end
        end
        S_STEP: begin
          if (n == '0) begin
            state <= S_FIN;
          end else begin
            cur <= step_nxt;
            n   <= n_next;
            if (step_err) begin
              err   <= 1'b1;
              state <= S_FIN;
            end
          end
        end
        S_DNA: state <= S_DNB;
        S_DNB: begin
          dn_a  <= dn;
          state <= S_DNC;
        end
        S_DNC: begin
          span  <= cdas_pkg::CNT_W'((dn_a > dn) ? (dn_a - dn) : (dn - dn_a));
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            out_year   <= cur.year;
            out_month  <= cur.month;
            out_day    <= cur.day;
            distance   <= span;
            error_flag <= err;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_acc_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != S_IDLE)
    else $error("accepted item left block idle");

  a_step_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && n == '0) |=> state == S_FIN)
    else $error("stepper did not finish on zero count");

  a_step_err: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && n != '0 && step_err) |=>
      (state == S_FIN && err && cur == cdas_pkg::DATE_DEF))
    else $error("failed check did not reset date");

  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !(out_valid && out_stall)) |=> (out_valid && state == S_IDLE))
    else $error("result not delivered to output register");

endmodule

// File: sv/cdas_step.sv
// cdas_step: one stepping iteration of the date (day run or month turn),
// forward or backward, with the validity check. Uses cdas_pkg.
module cdas_step (
  input  cdas_pkg::date_t            cur,
  input  logic [cdas_pkg::CNT_W-1:0] n,
  input  logic                       back,
  output cdas_pkg::date_t            nxt,
  output logic [cdas_pkg::CNT_W-1:0] n_nxt,
  output logic                       err
);

  logic [4:0] len;
  logic [4:0] room;
  logic [4:0] k;
  logic [3:0] pm;

  always_comb begin
    len   = cdas_pkg::month_len(cur.month, cur.year);
    pm    = cur.month - 4'd1;
    room  = back ? (cur.day - 5'd1) : (len - cur.day);
    k     = (n < cdas_pkg::CNT_W'(room)) ? n[4:0] : room;
    nxt   = cur;
    n_nxt = n;
    err   = 1'b0;
    if (!cdas_pkg::date_ok(cur)) begin
      nxt = cdas_pkg::DATE_DEF;
      err = 1'b1;
    end else if (room != 5'd0) begin
      nxt.day = back ? (cur.day - k) : (cur.day + k);
      n_nxt   = n - cdas_pkg::CNT_W'(k);
    end else begin
      n_nxt = n - cdas_pkg::CNT_W'(1);
      if (!back) begin
        nxt.day = 5'd1;
        if (cur.month < 4'd12) begin
          nxt.month = cur.month + 4'd1;
        end else begin
          nxt.month = 4'd1;
          nxt.year  = cur.year + 12'd1;
        end
      end else if (cur.month > 4'd1) begin
        nxt.month = pm;
        nxt.day   = cdas_pkg::month_len(pm, cur.year);
      end else begin
        nxt.year  = cur.year - 12'd1;
        nxt.month = 4'd12;
        nxt.day   = 5'd31;
      end
    end
  end

endmodule

// File: sv/cdas_daynum.sv
// cdas_daynum: registered serial day number of a date, shared by both
// operands of a difference. Uses cdas_pkg.
module cdas_daynum (
  input  logic                      clk,
  input  cdas_pkg::date_t           dt,
  output logic [cdas_pkg::DN_W-1:0] dn
);

  logic [11:0]               p;
  logic [cdas_pkg::DN_W-1:0] sum;

  always_comb begin
    p   = dt.year - 12'd1;
    sum = cdas_pkg::DN_W'(p) * cdas_pkg::DN_W'(365)
        + cdas_pkg::DN_W'(p[11:2])
        - cdas_pkg::DN_W'(cdas_pkg::div100(p))
        + cdas_pkg::DN_W'(cdas_pkg::div100({2'b00, p[11:2]}))
        + cdas_pkg::DN_W'(cdas_pkg::cum_days(dt.month))
        + cdas_pkg::DN_W'((dt.month > 4'd2) && cdas_pkg::is_leap(dt.year))
        + cdas_pkg::DN_W'(dt.day);
  end

  always_ff @(posedge clk) begin
    dn <= sum;
  end

endmodule
